// ----- design/assert_macros.svh -----
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define TWAC_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error("assertion failed");
`define TWAC_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define TWAC_ASSERT(lbl, clk, rstn, prop)
`define TWAC_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ----- design/twac_pkg.sv -----
package twac_pkg;
  localparam int unsigned WindowDepthDef = 256;
  localparam int unsigned SampleBitsDef = 16;
  localparam int unsigned TimeBits = 32;
  localparam int unsigned CountBits = 32;

  localparam logic [1:0] CfgAggregateMode = 2'd0;
  localparam logic [1:0] CfgCompareGreater = 2'd1;
  localparam logic [1:0] CfgWindowSpan = 2'd2;

  localparam logic [1:0] ModeAverage = 2'd0;
  localparam logic [1:0] ModeMinimum = 2'd1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_EV_RD, ST_EV_CHK, ST_CMP_RD, ST_CMP, ST_OV_RD, ST_OV_DROP,
    ST_INSERT, ST_QP_RD, ST_QP_CHK, ST_QPUSH, ST_DONE
  } state_e;
endpackage

// ----- design/time_window_aggregate_compare_core.sv -----
// channel   dir  tdata (low bit up)                              tuser
// s_axis    in   time_stamp[31:0], sample_value, zero pad        first_item
// m_axis    out  hit, hit_count[31:0], window_overflow, pad      -
// cfg       in   cfg_idx_i register index, cfg_data_i value      -
// one request steps through eviction, compare, insert and queue pop states; each evicted sample
// and popped queue entry needs a read through the single registered read port on the memories
// a full window adds a read and a drop state for the oldest sample
// reset clears pointers, counts and the output valid flag, memories and the output data are not cleared
// a result waiting on m_axis_tready does not block accepting the next request, only loading its result
`include "assert_macros.svh"
module time_window_aggregate_compare_core #(
  parameter int unsigned WindowDepth = twac_pkg::WindowDepthDef,
  parameter int unsigned SampleBits = twac_pkg::SampleBitsDef,
  localparam int unsigned InW = ((twac_pkg::TimeBits + SampleBits + 7) / 8) * 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [InW-1:0]       s_axis_tdata,  // time_stamp, sample_value
  input  logic                 s_axis_tuser,  // first_item
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [39:0]          m_axis_tdata,  // hit, hit_count, window_overflow
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_idx_i,
  input  logic [31:0]          cfg_data_i
);
  localparam int unsigned AW = (WindowDepth > 1) ? $clog2(WindowDepth) : 1;
  localparam int unsigned FW = $clog2(WindowDepth + 1);
  localparam int unsigned SW = SampleBits + FW;
  localparam int unsigned PW = SampleBits + FW + 1;
  localparam int unsigned TB = twac_pkg::TimeBits;

  twac_pkg::state_e state_q, state_d;
  logic [TB-1:0] t_q, t_d, span_q, span_d;
  logic signed [SampleBits-1:0] v_q, v_d;
  logic [1:0] mode_q, mode_d;
  logic gt_q, gt_d;
  logic [AW-1:0] whead_q, whead_d, qhead_q, qhead_d, slot_q, slot_d;
  logic [FW-1:0] wfill_q, wfill_d, qfill_q, qfill_d;
  logic signed [SW-1:0] sum_q, sum_d;
  logic signed [PW-1:0] prod_q, prod_d;
  logic [twac_pkg::CountBits-1:0] hits_q, hits_d;
  logic hit_q, hit_d, ovf_q, ovf_d;
  logic out_valid_q, out_valid_d;
  logic [39:0] out_data_q, out_data_d;

  logic w_we, q_we;
  logic [AW-1:0] w_waddr, w_raddr, q_waddr, q_raddr;
  logic [TB+SampleBits-1:0] w_rdata;
  logic [AW+SampleBits-1:0] q_rdata;
  logic [TB-1:0] w_time;
  logic signed [SampleBits-1:0] w_val, q_val;
  logic [AW-1:0] q_slot;
  logic [AW:0] wpos_sum, qpos_sum, qback_sum;
  logic [AW-1:0] wpos, qpos, qback, whead_inc, qhead_inc;
  logic stale, drop, pop, cmp_res;
  logic signed [PW-1:0] lhs, rhs;

  assign w_time = w_rdata[TB+SampleBits-1:SampleBits];
  assign w_val = w_rdata[SampleBits-1:0];
  assign q_slot = q_rdata[AW+SampleBits-1:SampleBits];
  assign q_val = q_rdata[SampleBits-1:0];

  assign whead_inc = (whead_q == AW'(WindowDepth - 1)) ? '0 : whead_q + AW'(1);
  assign qhead_inc = (qhead_q == AW'(WindowDepth - 1)) ? '0 : qhead_q + AW'(1);
  assign wpos_sum = (AW+1)'(whead_q) + (AW+1)'(wfill_q);
  assign wpos = (wpos_sum >= (AW+1)'(WindowDepth)) ?
                AW'(wpos_sum - (AW+1)'(WindowDepth)) : AW'(wpos_sum);
  assign qpos_sum = (AW+1)'(qhead_q) + (AW+1)'(qfill_q);
  assign qpos = (qpos_sum >= (AW+1)'(WindowDepth)) ?
                AW'(qpos_sum - (AW+1)'(WindowDepth)) : AW'(qpos_sum);
  assign qback_sum = qpos_sum - (AW+1)'(1);
  assign qback = (qback_sum >= (AW+1)'(WindowDepth)) ?
                 AW'(qback_sum - (AW+1)'(WindowDepth)) : AW'(qback_sum);

  assign stale = {1'b0, t_q} > ({1'b0, w_time} + {1'b0, span_q});
  assign drop = (state_q == twac_pkg::ST_EV_CHK && stale) || state_q == twac_pkg::ST_OV_DROP;
  assign pop = (mode_q == twac_pkg::ModeMinimum) ? (q_val > v_q) : (q_val < v_q);

  always_comb begin
    if (mode_q == twac_pkg::ModeAverage) begin
      lhs = prod_q;
      rhs = PW'(sum_q);
    end else begin
      lhs = PW'(v_q);
      rhs = (qfill_q != '0) ? PW'(q_val) : PW'(v_q);
    end
    cmp_res = gt_q ? (lhs > rhs) : (lhs < rhs);
  end

  assign s_axis_tready = (state_q == twac_pkg::ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata = out_data_q;

  always_comb begin
    state_d = state_q;
    t_d = t_q; v_d = v_q; span_d = span_q; mode_d = mode_q; gt_d = gt_q;
    whead_d = whead_q; wfill_d = wfill_q; qhead_d = qhead_q; qfill_d = qfill_q;
    slot_d = slot_q; sum_d = sum_q; prod_d = prod_q; hits_d = hits_q;
    hit_d = hit_q; ovf_d = ovf_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_data_d = out_data_q;
    w_we = 1'b0; q_we = 1'b0;
    w_waddr = wpos; q_waddr = qpos;
    w_raddr = whead_q;
    q_raddr = (state_q == twac_pkg::ST_QP_RD) ? qback : qhead_q;

    if (drop) begin
      sum_d = sum_q - SW'(w_val);
      if (qfill_q != '0 && q_slot == whead_q) begin
        qhead_d = qhead_inc;
        qfill_d = qfill_q - FW'(1);
      end
      whead_d = whead_inc;
      wfill_d = wfill_q - FW'(1);
    end

    case (state_q)
      twac_pkg::ST_IDLE: begin
        if (s_axis_tvalid) begin
          t_d = s_axis_tdata[TB-1:0];
          v_d = s_axis_tdata[TB+SampleBits-1:TB];
          if (s_axis_tuser) begin
            whead_d = '0; wfill_d = '0; qhead_d = '0; qfill_d = '0;
            sum_d = '0; hits_d = '0;
          end
          state_d = twac_pkg::ST_EV_RD;
        end
      end
      twac_pkg::ST_EV_RD: begin
        state_d = (wfill_q != '0) ? twac_pkg::ST_EV_CHK : twac_pkg::ST_CMP_RD;
      end
      twac_pkg::ST_EV_CHK: begin
        state_d = stale ? twac_pkg::ST_EV_RD : twac_pkg::ST_CMP_RD;
      end
      twac_pkg::ST_CMP_RD: begin
        prod_d = PW'(v_q) * $signed({1'b0, wfill_q});
        state_d = twac_pkg::ST_CMP;
      end
      twac_pkg::ST_CMP: begin
        hit_d = (wfill_q != '0) && cmp_res;
        if (hit_d) begin
          hits_d = hits_q + 1'b1;
        end
        ovf_d = (wfill_q == FW'(WindowDepth));
        state_d = ovf_d ? twac_pkg::ST_OV_RD : twac_pkg::ST_INSERT;
      end
      twac_pkg::ST_OV_RD: state_d = twac_pkg::ST_OV_DROP;
      twac_pkg::ST_OV_DROP: state_d = twac_pkg::ST_INSERT;
      twac_pkg::ST_INSERT: begin
        w_we = 1'b1;
        slot_d = wpos;
        wfill_d = wfill_q + FW'(1);
        sum_d = sum_q + SW'(v_q);
        state_d = twac_pkg::ST_QP_RD;
      end
      twac_pkg::ST_QP_RD: begin
        state_d = (qfill_q != '0) ? twac_pkg::ST_QP_CHK : twac_pkg::ST_QPUSH;
      end
      twac_pkg::ST_QP_CHK: begin
        if (pop) begin
          qfill_d = qfill_q - FW'(1);
          state_d = twac_pkg::ST_QP_RD;
        end else begin
          state_d = twac_pkg::ST_QPUSH;
        end
      end
      twac_pkg::ST_QPUSH: begin
        q_we = 1'b1;
        qfill_d = qfill_q + FW'(1);
        state_d = twac_pkg::ST_DONE;
      end
      twac_pkg::ST_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_data_d = {6'd0, ovf_q, hits_q, hit_q};
          state_d = twac_pkg::ST_IDLE;
        end
      end
      default: state_d = twac_pkg::ST_IDLE;
    endcase

    if (cfg_we_i) begin
      case (cfg_idx_i)
        twac_pkg::CfgAggregateMode: begin
          mode_d = cfg_data_i[1:0];
          qhead_d = '0;
          qfill_d = '0;
        end
        twac_pkg::CfgCompareGreater: gt_d = cfg_data_i[0];
        twac_pkg::CfgWindowSpan: span_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= twac_pkg::ST_IDLE;
      mode_q <= twac_pkg::ModeAverage;
      gt_q <= 1'b1;
      span_q <= '0;
      whead_q <= '0; wfill_q <= '0; qhead_q <= '0; qfill_q <= '0;
      sum_q <= '0; hits_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      mode_q <= mode_d;
      gt_q <= gt_d;
      span_q <= span_d;
      whead_q <= whead_d; wfill_q <= wfill_d; qhead_q <= qhead_d; qfill_q <= qfill_d;
      sum_q <= sum_d; hits_q <= hits_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    t_q <= t_d; v_q <= v_d; slot_q <= slot_d; prod_q <= prod_d;
    hit_q <= hit_d; ovf_q <= ovf_d; out_data_q <= out_data_d;
  end

  twac_ram #(.Width(TB + SampleBits), .Depth(WindowDepth)) u_window_ram (
    .clk_i, .we_i(w_we), .waddr_i(w_waddr), .wdata_i({t_q, v_q}),
    .raddr_i(w_raddr), .rdata_o(w_rdata)
  );

  twac_ram #(.Width(AW + SampleBits), .Depth(WindowDepth)) u_queue_ram (
    .clk_i, .we_i(q_we), .waddr_i(q_waddr), .wdata_i({slot_q, v_q}),
    .raddr_i(q_raddr), .rdata_o(q_rdata)
  );

  `TWAC_ASSERT(a_fill_bound, clk_i, rst_ni, wfill_q <= FW'(WindowDepth))
  `TWAC_ASSERT(a_queue_in_window, clk_i, rst_ni, qfill_q <= wfill_q)
  `TWAC_ASSERT(a_accept_busy, clk_i, rst_ni, s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
  `TWAC_ASSERT(a_done_loads, clk_i, rst_ni,
    state_q == twac_pkg::ST_DONE && state_d == twac_pkg::ST_IDLE |=> m_axis_tvalid)
endmodule

// ----- design/twac_ram.sv -----
module twac_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
